>>> hw/rtl/eors_pkg.sv
package eors_pkg;

  // Field widths of the request and result channels
  localparam int CMD_W    = 2;
  localparam int ADDR_W   = 16;
  localparam int WORD_W   = 32;
  localparam int PC_W     = 16;

  // Default memory depth; any value from 256 to 65536 words is supported
  localparam int DEF_MEM_WORDS = 65536;

  // Register file geometry (fixed by the instruction format)
  localparam int REG_COUNT = 8;
  localparam int RIDX_W    = 3;

  // Instruction word layout
  localparam int OPC_LSB = 22;
  localparam int RA_LSB  = 19;
  localparam int RB_LSB  = 16;
  localparam int FLD_W   = 16;

  // Request commands
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_EXEC  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RDMEM = 2'd2;
  localparam logic [CMD_W-1:0] CMD_RDREG = 2'd3;

  // Opcodes
  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_NOR  = 3'd1;
  localparam logic [2:0] OP_LW   = 3'd2;
  localparam logic [2:0] OP_SW   = 3'd3;
  localparam logic [2:0] OP_BEQ  = 3'd4;
  localparam logic [2:0] OP_JALR = 3'd5;
  localparam logic [2:0] OP_HALT = 3'd6;
  localparam logic [2:0] OP_NOOP = 3'd7;

  // Register file access for one cycle
  typedef struct packed {
    logic              rd_en;
    logic [RIDX_W-1:0] ra;
    logic [RIDX_W-1:0] rb;
    logic              we;
    logic [RIDX_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
  } rf_req_t;

  // Registered read data of both register file ports
  typedef struct packed {
    logic [WORD_W-1:0] ra_data;
    logic [WORD_W-1:0] rb_data;
  } rf_rsp_t;

endpackage

>>> hw/rtl/eors_req_if.sv
interface eors_req_if import eors_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic [ADDR_W-1:0]        address;
  logic signed [WORD_W-1:0] data;

  modport source (output valid, cmd, address, data, input ready);
  modport sink   (input valid, cmd, address, data, output ready);
endinterface

>>> hw/rtl/eors_rsp_if.sv
interface eors_rsp_if import eors_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [PC_W-1:0]          pc_now;
  logic                     halted;
  logic [WORD_W-1:0]        executed_count;
  logic signed [WORD_W-1:0] read_data;

  modport source (output valid, pc_now, halted, executed_count, read_data, input ready);
  modport sink   (input valid, pc_now, halted, executed_count, read_data, output ready);
endinterface

>>> hw/rtl/eight_opcode_risc_step_core.sv
// Eight-opcode word machine with a single-port synchronous word memory and an
// eight-entry register file. Each request (load word, execute one instruction,
// read word, read register) yields exactly one result carrying the pc, the halt
// flag, the executed-instruction count and the read data. Requests are handled
// one at a time by a sequencer that shares the one memory port between
// instruction fetch, data access and host access. An execute request fetches
// the instruction, reads both registers and executes it; lw, sw, a taken beq
// and a jalr whose two registers differ then reduce an address, and lw then
// reads the word and writes its register. An execute request after a halt
// returns its result without a fetch. A result that finds the output register
// still occupied waits there for as long as the previous one stalls. Every
// address reduction (host address, regA + offset, branch and jump targets)
// passes through the address wrap unit. A new request is taken while the
// previous result still waits in the output register. Memory words must be
// written before they are fetched or read.
module eight_opcode_risc_step_core import eors_pkg::*; #(
  parameter int MEM_WORDS = DEF_MEM_WORDS
) (
  input  logic      clk,
  input  logic      rst,
  eors_req_if.sink   req,
  eors_rsp_if.source rsp
);

  localparam int AW = $clog2(MEM_WORDS);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_AMOD  = 4'd1;
  localparam logic [3:0] S_MRD   = 4'd2;
  localparam logic [3:0] S_RREG  = 4'd3;
  localparam logic [3:0] S_FETCH = 4'd4;
  localparam logic [3:0] S_EXEC  = 4'd5;
  localparam logic [3:0] S_XMOD  = 4'd6;
  localparam logic [3:0] S_LW    = 4'd7;
  localparam logic [3:0] S_RESP  = 4'd8;

  logic [3:0]        state;
  logic [AW-1:0]     pc;
  logic              halted;
  logic [WORD_W-1:0] icount;
  logic [CMD_W-1:0]  cmd_q;
  logic [WORD_W-1:0] data_q;
  logic [WORD_W-1:0] ins_q;
  logic [WORD_W-1:0] rd_q;

  // Word memory
  logic [WORD_W-1:0] word_mem [MEM_WORDS];
  logic              mem_we;
  logic              mem_re;
  logic [AW-1:0]     mem_addr;
  logic [WORD_W-1:0] mem_wdata;
  logic [WORD_W-1:0] mem_q;

  // Register file and address wrap unit
  rf_req_t           rf_req;
  rf_rsp_t           rf_rsp;
  logic              wrap_start;
  logic [WORD_W-1:0] wrap_value;
  logic              wrap_done;
  logic [AW-1:0]     wrap_result;

  // Decoded instruction
  logic [2:0]        op;
  logic [RIDX_W-1:0] ra;
  logic [RIDX_W-1:0] rb;
  logic [FLD_W-1:0]  fld;
  logic [WORD_W-1:0] off32;
  logic [AW-1:0]     pc_inc;
  logic              regs_equal;
  logic              out_free;

  assign op         = ins_q[OPC_LSB +: 3];
  assign ra         = ins_q[RA_LSB +: RIDX_W];
  assign rb         = ins_q[RB_LSB +: RIDX_W];
  assign fld        = ins_q[FLD_W-1:0];
  assign off32      = {{(WORD_W-FLD_W){fld[FLD_W-1]}}, fld};
  assign pc_inc     = (pc == AW'(MEM_WORDS - 1)) ? '0 : pc + 1'b1;
  assign regs_equal = (rf_rsp.ra_data == rf_rsp.rb_data);
  assign out_free   = !rsp.valid || rsp.ready;

  assign req.ready = (state == S_IDLE);

  eors_regfile u_regfile (
    .clk (clk),
    .rst (rst),
    .req (rf_req),
    .rsp (rf_rsp)
  );

  eors_addr_wrap #(
    .MEM_WORDS (MEM_WORDS)
  ) u_addr_wrap (
    .clk    (clk),
    .rst    (rst),
    .start  (wrap_start),
    .value  (wrap_value),
    .done   (wrap_done),
    .result (wrap_result)
  );

  // Memory port: one read or one write per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      word_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= word_mem[mem_addr];
    end
  end

  // Drive memory, register file and wrap unit for the current step
  always_comb begin
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_addr   = pc;
    mem_wdata  = data_q;
    rf_req     = '0;
    wrap_start = 1'b0;
    wrap_value = '0;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          unique case (req.cmd)
            CMD_LOAD, CMD_RDMEM: begin
              wrap_start = 1'b1;
              wrap_value = WORD_W'(req.address);
            end
            CMD_EXEC: begin
              mem_re = !halted;
            end
            CMD_RDREG: begin
              rf_req.rd_en = 1'b1;
              rf_req.ra    = req.address[RIDX_W-1:0];
            end
          endcase
        end
      end
      S_AMOD: begin
        mem_addr = wrap_result;
        if (wrap_done) begin
          mem_we = (cmd_q == CMD_LOAD);
          mem_re = (cmd_q != CMD_LOAD);
        end
      end
      S_FETCH: begin
        rf_req.rd_en = 1'b1;
        rf_req.ra    = mem_q[RA_LSB +: RIDX_W];
        rf_req.rb    = mem_q[RB_LSB +: RIDX_W];
      end
      S_EXEC: begin
        unique case (op)
          OP_ADD: begin
            rf_req.we    = 1'b1;
            rf_req.waddr = fld[RIDX_W-1:0];
            rf_req.wdata = rf_rsp.ra_data + rf_rsp.rb_data;
          end
          OP_NOR: begin
            rf_req.we    = 1'b1;
            rf_req.waddr = fld[RIDX_W-1:0];
            rf_req.wdata = ~(rf_rsp.ra_data | rf_rsp.rb_data);
          end
          OP_LW, OP_SW: begin
            wrap_start = 1'b1;
            wrap_value = rf_rsp.ra_data + off32;
          end
          OP_BEQ: begin
            wrap_start = regs_equal;
            wrap_value = WORD_W'(pc_inc) + off32;
          end
          OP_JALR: begin
            rf_req.we    = 1'b1;
            rf_req.waddr = rb;
            rf_req.wdata = WORD_W'(pc_inc);
            wrap_start   = (ra != rb);
            wrap_value   = rf_rsp.ra_data;
          end
          OP_HALT, OP_NOOP: begin
          end
        endcase
      end
      S_XMOD: begin
        mem_addr  = wrap_result;
        mem_wdata = rf_rsp.rb_data;
        if (wrap_done) begin
          mem_re = (op == OP_LW);
          mem_we = (op == OP_SW);
        end
      end
      S_LW: begin
        rf_req.we    = 1'b1;
        rf_req.waddr = rb;
        rf_req.wdata = mem_q;
      end
      S_MRD, S_RREG, S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  // Sequencer and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= '0;
      halted    <= 1'b0;
      icount    <= '0;
      rsp.valid <= 1'b0;
    end else begin
      // Load the result when the output register frees, drop it once taken
      if ((state == S_RESP) && out_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            cmd_q  <= req.cmd;
            data_q <= req.data;
            rd_q   <= '0;
            unique case (req.cmd)
              CMD_LOAD, CMD_RDMEM: state <= S_AMOD;
              CMD_EXEC:            state <= halted ? S_RESP : S_FETCH;
              CMD_RDREG:           state <= S_RREG;
            endcase
          end
        end
        S_AMOD: begin
          if (wrap_done) begin
            state <= (cmd_q == CMD_LOAD) ? S_RESP : S_MRD;
          end
        end
        S_MRD: begin
          rd_q  <= mem_q;
          state <= S_RESP;
        end
        S_RREG: begin
          rd_q  <= rf_rsp.ra_data;
          state <= S_RESP;
        end
        S_FETCH: begin
          ins_q <= mem_q;
          state <= S_EXEC;
        end
        S_EXEC: begin
          icount <= icount + 1'b1;
          pc     <= pc_inc;
          state  <= S_RESP;
          unique case (op)
            OP_LW, OP_SW: state <= S_XMOD;
            OP_BEQ:       state <= regs_equal ? S_XMOD : S_RESP;
            OP_JALR:      state <= (ra != rb) ? S_XMOD : S_RESP;
            OP_HALT:      halted <= 1'b1;
            OP_ADD, OP_NOR, OP_NOOP: begin
            end
          endcase
        end
        S_XMOD: begin
          if (wrap_done) begin
            unique case (op)
              OP_LW:           state <= S_LW;
              OP_BEQ, OP_JALR: begin
                pc    <= wrap_result;
                state <= S_RESP;
              end
              default:         state <= S_RESP;
            endcase
          end
        end
        S_LW: begin
          state <= S_RESP;
        end
        S_RESP: begin
          // Return to idle once the output register takes the result
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if ((state == S_RESP) && out_free) begin
      rsp.pc_now         <= PC_W'(pc);
      rsp.halted         <= halted;
      rsp.executed_count <= icount;
      rsp.read_data      <= rd_q;
    end
  end

endmodule

>>> hw/rtl/eors_regfile.sv
module eors_regfile import eors_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  rf_req_t req,
  output rf_rsp_t rsp
);

  logic [WORD_W-1:0]    regs [REG_COUNT];
  logic [REG_COUNT-1:0] written;

  // Track which entries hold a written value; others read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (req.we) begin
      written[req.waddr] <= 1'b1;
    end
  end

  // Write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      regs[req.waddr] <= req.wdata;
    end
  end

  // Two registered read ports; hold data until the next read
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rsp.ra_data <= written[req.ra] ? regs[req.ra] : '0;
      rsp.rb_data <= written[req.rb] ? regs[req.rb] : '0;
    end
  end

endmodule

>>> hw/rtl/eors_addr_wrap.sv
module eors_addr_wrap import eors_pkg::*; #(
  parameter int MEM_WORDS = DEF_MEM_WORDS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [WORD_W-1:0]            value,
  output logic                         done,
  output logic [$clog2(MEM_WORDS)-1:0] result
);

  localparam int AW      = $clog2(MEM_WORDS);
  localparam bit IS_POW2 = ((1 << AW) == MEM_WORDS);

  if (IS_POW2) begin : g_mask
    // Power-of-two depth: keep the low address bits
    always_ff @(posedge clk) begin
      if (rst) begin
        done <= 1'b0;
      end else begin
        done <= start;
      end
    end

    always_ff @(posedge clk) begin
      if (start) begin
        result <= value[AW-1:0];
      end
    end
  end else begin : g_recip
    // Quotient estimate from a truncated reciprocal; it is low by at most one,
    // so the remainder after multiplying back is below twice the depth
    localparam int            QW         = WORD_W - 8;
    localparam logic [63:0]   RECIP_FULL = (64'd1 << WORD_W) / 64'(MEM_WORDS);
    localparam logic [QW-1:0] RECIP      = QW'(RECIP_FULL);
    localparam logic [AW:0]   MOD_C      = (AW+1)'(MEM_WORDS);

    logic [1:0]           vld;
    logic [WORD_W-1:0]    val_q;
    logic [WORD_W+QW-1:0] prod_q;
    logic [QW-1:0]        quot;
    logic [WORD_W-1:0]    back;
    logic [AW:0]          rem_q;

    assign quot = prod_q[WORD_W +: QW];
    assign back = val_q - (WORD_W'(quot) * WORD_W'(MOD_C));

    // Advance the three stages
    always_ff @(posedge clk) begin
      if (rst) begin
        vld  <= '0;
        done <= 1'b0;
      end else begin
        vld  <= {vld[0], start};
        done <= vld[1];
      end
    end

    // Multiply by the reciprocal, multiply back, then one compare and subtract
    always_ff @(posedge clk) begin
      if (start) begin
        val_q  <= value;
        prod_q <= (WORD_W+QW)'(value) * (WORD_W+QW)'(RECIP);
      end
      if (vld[0]) begin
        rem_q <= back[AW:0];
      end
      if (vld[1]) begin
        result <= (rem_q >= MOD_C) ? (rem_q[AW-1:0] - MOD_C[AW-1:0]) : rem_q[AW-1:0];
      end
    end
  end

endmodule

>>> hw/rtl/eors_checker.sv
module eors_checker import eors_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic [PC_W-1:0]   rsp_pc_now,
  input logic              rsp_halted,
  input logic [WORD_W-1:0] rsp_count
);

  logic              req_xfer;
  logic              rsp_xfer;
  logic [1:0]        pending;
  logic              have_last;
  logic              seen_halt;
  logic [WORD_W-1:0] last_count;

  assign req_xfer = req_valid && req_ready;
  assign rsp_xfer = rsp_valid && rsp_ready;

  // Track items in flight and the last reported state
  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= '0;
      have_last <= 1'b0;
      seen_halt <= 1'b0;
    end else begin
      pending <= pending + 2'(req_xfer) - 2'(rsp_xfer);
      if (rsp_xfer) begin
        have_last <= 1'b1;
        seen_halt <= seen_halt || rsp_halted;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_xfer) begin
      last_count <= rsp_count;
    end
  end

  // A stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pc_now) && $stable(rsp_count))
    else $error("result changed while stalled");

  // At most one item in work and one result waiting
  a_no_third: assert property (@(posedge clk) disable iff (rst)
    req_xfer |-> pending != 2'd2)
    else $error("request taken with two items outstanding");

  // No result without an item behind it
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending != 2'd0)
    else $error("result with no outstanding item");

  // Count advances by at most one per result
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    rsp_xfer && have_last |-> rsp_count == last_count || rsp_count == last_count + 1'b1)
    else $error("instruction count jumped");

  // Once halted, stay halted and stop counting
  a_halt_frozen: assert property (@(posedge clk) disable iff (rst)
    rsp_xfer && seen_halt |-> rsp_halted && rsp_count == last_count)
    else $error("machine ran after halt");

endmodule

bind eight_opcode_risc_step_core eors_checker u_eors_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_pc_now (rsp.pc_now),
  .rsp_halted (rsp.halted),
  .rsp_count  (rsp.executed_count)
);

>>> tb/eight_opcode_risc_step_core_test.sv
`timescale 1ns / 1ps

module eight_opcode_risc_step_core_test import eors_pkg::*; ();

  localparam int unsigned MEM_DEPTH        = DEF_MEM_WORDS;
  localparam int unsigned LONG_HOLD_CYCLES = 200;
  localparam int unsigned RANDOM_ITEMS     = 1550;

  typedef struct {
    logic [PC_W-1:0]   pc_now;
    logic              halted;
    logic [WORD_W-1:0] executed_count;
    logic [WORD_W-1:0] read_data;
  } step_result_t;

  logic clk;
  logic rst;

  eors_req_if req ();
  eors_rsp_if rsp ();

  eight_opcode_risc_step_core #(
    .MEM_WORDS(MEM_DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  // Machine image kept by the testbench
  logic [WORD_W-1:0] mem_img [MEM_DEPTH];
  bit                mem_valid [MEM_DEPTH];
  int unsigned       written_addrs [$];
  logic [WORD_W-1:0] reg_img [REG_COUNT];
  int unsigned       pc_img;
  logic              halt_img;
  logic [WORD_W-1:0] exec_count_img;

  step_result_t expected_results [$];

  int unsigned errors;
  int unsigned items_sent;
  int unsigned burst_left;
  int unsigned holds_requested;
  int unsigned holds_granted;
  bit          gaps_on;
  bit          halt_allowed;

  initial begin
    for (int i = 0; i < REG_COUNT; i++) reg_img[i] = '0;
    pc_img          = 0;
    halt_img        = 1'b0;
    exec_count_img  = '0;
    errors          = 0;
    items_sent      = 0;
    burst_left      = 0;
    holds_requested = 0;
    holds_granted   = 0;
    gaps_on         = 1'b1;
    halt_allowed    = 1'b0;
  end

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned wrap_addr(logic [31:0] a);
    return a % MEM_DEPTH;
  endfunction

  function automatic void store_word(int unsigned a, logic [WORD_W-1:0] w);
    if (!mem_valid[a]) begin
      mem_valid[a] = 1'b1;
      written_addrs.push_back(a);
    end
    mem_img[a] = w;
  endfunction

  function automatic logic [WORD_W-1:0] fetch_word(int unsigned a);
    return mem_valid[a] ? mem_img[a] : '0;
  endfunction

  // Advance the image by one request and return the result it must produce
  function automatic step_result_t apply_request(logic [CMD_W-1:0] cmd,
                                                 logic [ADDR_W-1:0] address,
                                                 logic [WORD_W-1:0] data);
    step_result_t      res;
    logic [WORD_W-1:0] ins;
    logic [WORD_W-1:0] offset;
    logic [2:0]        op;
    logic [2:0]        ra;
    logic [2:0]        rb;
    int unsigned       next_pc;
    res.read_data = '0;
    case (cmd)
      CMD_LOAD: store_word(wrap_addr(32'(address)), data);
      CMD_EXEC: begin
        if (!halt_img) begin
          ins     = fetch_word(pc_img);
          op      = ins[OPC_LSB +: 3];
          ra      = ins[RA_LSB +: RIDX_W];
          rb      = ins[RB_LSB +: RIDX_W];
          offset  = {{(WORD_W-FLD_W){ins[FLD_W-1]}}, ins[FLD_W-1:0]};
          next_pc = wrap_addr(pc_img + 1);
          exec_count_img = exec_count_img + 1'b1;
          case (op)
            OP_ADD:  reg_img[ins[2:0]] = reg_img[ra] + reg_img[rb];
            OP_NOR:  reg_img[ins[2:0]] = ~(reg_img[ra] | reg_img[rb]);
            OP_LW:   reg_img[rb] = fetch_word(wrap_addr(reg_img[ra] + offset));
            OP_SW:   store_word(wrap_addr(reg_img[ra] + offset), reg_img[rb]);
            OP_BEQ: begin
              if (reg_img[ra] == reg_img[rb]) next_pc = wrap_addr(next_pc + offset);
            end
            // link first, then read regA, so a shared register yields pc + 1
            OP_JALR: begin
              reg_img[rb] = next_pc;
              next_pc     = wrap_addr(reg_img[ra]);
            end
            OP_HALT: halt_img = 1'b1;
            default: ;
          endcase
          pc_img = next_pc;
        end
      end
      CMD_RDMEM: res.read_data = fetch_word(wrap_addr(32'(address)));
      default:   res.read_data = reg_img[address[RIDX_W-1:0]];
    endcase
    res.pc_now         = PC_W'(pc_img);
    res.halted         = halt_img;
    res.executed_count = exec_count_img;
    return res;
  endfunction

  function automatic logic [WORD_W-1:0] encode(logic [2:0] op, logic [2:0] ra,
                                               logic [2:0] rb, logic [FLD_W-1:0] fld);
    return {7'b0, op, ra, rb, fld};
  endfunction

  // Pick any opcode but halt, with offsets that mostly stay near the code
  function automatic logic [WORD_W-1:0] random_instr();
    logic [2:0]       op;
    logic [FLD_W-1:0] fld;
    int unsigned      pick;
    pick = $urandom_range(0, 99);
    if (pick < 18)      op = OP_ADD;
    else if (pick < 28) op = OP_NOR;
    else if (pick < 46) op = OP_LW;
    else if (pick < 60) op = OP_SW;
    else if (pick < 78) op = OP_BEQ;
    else if (pick < 88) op = OP_JALR;
    else                op = OP_NOOP;
    case (op)
      OP_LW, OP_SW: begin
        if ($urandom_range(0, 3) == 0) fld = 16'($urandom);
        else fld = 16'($urandom_range(0, 16)) - 16'd8;
      end
      OP_BEQ: begin
        if ($urandom_range(0, 4) == 0) fld = 16'($urandom);
        else fld = 16'($urandom_range(0, 12)) - 16'd6;
      end
      default: fld = 16'($urandom);
    endcase
    return encode(op, 3'($urandom), 3'($urandom), fld) | {7'($urandom), 25'b0};
  endfunction

  // Data words: full range, small values, near the pc, near the top of memory
  function automatic logic [WORD_W-1:0] random_data();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return 32'($urandom_range(0, 31));
      2:       return 32'(pc_img + $urandom_range(0, 15));
      default: return 32'hFFFF_FFE0 + 32'($urandom_range(0, 31));
    endcase
  endfunction

  // Offer one request, predict its result, hold until the transfer
  task automatic send_item(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] address,
                           logic [WORD_W-1:0] data);
    step_result_t want;
    int unsigned  gap;
    gap = 0;
    if (gaps_on) begin
      if (burst_left == 0) begin
        gap        = $urandom_range(1, 6);
        burst_left = $urandom_range(1, 16);
      end
      burst_left--;
    end
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid   <= 1'b1;
    req.cmd     <= cmd;
    req.address <= address;
    req.data    <= data;
    want = apply_request(cmd, address, data);
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    expected_results.push_back(want);
    items_sent++;
  endtask

  task automatic load_word(logic [ADDR_W-1:0] address, logic [WORD_W-1:0] word);
    send_item(CMD_LOAD, address, word);
  endtask

  task automatic read_mem(logic [ADDR_W-1:0] address);
    send_item(CMD_RDMEM, address, $urandom);
  endtask

  task automatic read_reg(logic [ADDR_W-1:0] address);
    send_item(CMD_RDREG, address, $urandom);
  endtask

  task automatic read_known_word();
    read_mem(16'(written_addrs[$urandom_range(0, written_addrs.size() - 1)]));
  endtask

  // Make sure the fetch and any lw source are written, then execute one step
  task automatic exec_step();
    logic [WORD_W-1:0] ins;
    int unsigned       target;
    if (!halt_img) begin
      if (!mem_valid[pc_img] ||
          (!halt_allowed && mem_img[pc_img][OPC_LSB +: 3] == OP_HALT))
        load_word(16'(pc_img), random_instr());
      ins = mem_img[pc_img];
      if (ins[OPC_LSB +: 3] == OP_LW) begin
        target = wrap_addr(reg_img[ins[RA_LSB +: RIDX_W]] +
                           {{(WORD_W-FLD_W){ins[FLD_W-1]}}, ins[FLD_W-1:0]});
        if (!mem_valid[target]) load_word(16'(target), random_data());
      end
    end
    send_item(CMD_EXEC, 16'($urandom), $urandom);
  endtask

  // Lay down a short program at the pc and run through it
  task automatic run_program(int unsigned len);
    int unsigned base;
    base = pc_img;
    for (int unsigned i = 0; i < len; i++)
      load_word(16'(wrap_addr(base + i)), random_instr());
    for (int unsigned i = 0; i <= len; i++) begin
      exec_step();
      if ($urandom_range(0, 5) == 0) read_reg(16'($urandom));
    end
  endtask

  task automatic random_step();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40)      exec_step();
    else if (pick < 62) run_program($urandom_range(2, 10));
    else if (pick < 72) load_word(16'($urandom), random_data());
    else if (pick < 86) read_known_word();
    else                read_reg(16'($urandom));
  endtask

  task automatic test_reset_state();
    read_reg(16'hFFF8);
    read_reg(16'h0005);
  endtask

  // lw, add, nor, sw to a negative wrapped address, taken beq, jalr to the
  // top word, which then runs the stored sum as an add and wraps the pc to 0
  task automatic test_program_paths();
    load_word(16'd16, 32'h0000_FFFF);
    load_word(16'd17, 32'h8000_0001);
    load_word(16'd0, encode(OP_LW, 3'd0, 3'd1, 16'd16));
    load_word(16'd1, encode(OP_LW, 3'd0, 3'd2, 16'd17));
    load_word(16'd2, encode(OP_ADD, 3'd1, 3'd2, 16'hFFF3));
    load_word(16'd3, encode(OP_NOR, 3'd1, 3'd2, 16'h0004));
    load_word(16'd4, encode(OP_SW, 3'd0, 3'd3, 16'hFFFF));
    load_word(16'd5, encode(OP_BEQ, 3'd5, 3'd6, 16'h7FFF));
    load_word(16'h8005, encode(OP_JALR, 3'd1, 3'd7, 16'h0000));
    repeat (8) exec_step();
    read_mem(16'hFFFF);
    read_reg(16'hFFFB);
    read_reg(16'h0007);
  endtask

  task automatic test_jalr_same_register();
    load_word(16'd0, encode(OP_JALR, 3'd2, 3'd2, 16'h1234));
    exec_step();
    load_word(16'd1, encode(OP_NOOP, 3'd7, 3'd7, 16'hFFFF) | 32'hFE00_0000);
    exec_step();
  endtask

  task automatic test_random_traffic();
    int unsigned goal;
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      if ($urandom_range(0, 39) == 0) gaps_on = ($urandom_range(0, 3) != 0);
      random_step();
    end
    gaps_on = 1'b1;
  endtask

  // Hold off the result side while requests keep coming back to back
  task automatic test_output_backpressure();
    gaps_on = 1'b0;
    holds_requested++;
    repeat (16) random_step();
    gaps_on = 1'b1;
  endtask

  // Halt is counted, later steps change nothing, host access still works
  task automatic test_halt_behavior();
    halt_allowed = 1'b1;
    load_word(16'(pc_img),
              encode(OP_HALT, 3'($urandom), 3'($urandom), 16'($urandom)) | 32'hFE00_0000);
    exec_step();
    repeat (3) exec_step();
    load_word(16'($urandom), $urandom);
    read_known_word();
    read_reg(16'($urandom));
    exec_step();
  endtask

  // Stimulus and end of run
  initial begin : stimulus
    rst         <= 1'b1;
    req.valid   <= 1'b0;
    req.cmd     <= CMD_LOAD;
    req.address <= '0;
    req.data    <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_program_paths();
    test_jalr_same_register();
    test_random_traffic();
    test_output_backpressure();
    test_halt_behavior();
    req.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // Result side stall pattern, with a long hold on request
  initial begin : result_stalls
    logic [7:0]  pattern;
    int unsigned mode_left;
    int unsigned hold_left;
    rsp.ready <= 1'b0;
    pattern   = 8'hFF;
    mode_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && holds_granted != holds_requested) begin
        hold_left = LONG_HOLD_CYCLES;
        holds_granted++;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode_left = $urandom_range(32, 200);
          case ($urandom_range(0, 3))
            0:       pattern = 8'hFF;
            1:       pattern = 8'($urandom) | 8'h01;
            2:       pattern = 8'b1000_0001;
            default: pattern = 8'b1110_1110;
          endcase
        end
        mode_left--;
        rsp.ready <= pattern[0];
        pattern = {pattern[0], pattern[7:1]};
      end
    end
  end

  // Compare every result transfer with the oldest prediction
  always @(posedge clk) begin : check_results
    step_result_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with no request outstanding, pc_now %h count %h",
                 $time, rsp.pc_now, rsp.executed_count);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (rsp.pc_now !== want.pc_now) begin
          $display("%0t: pc_now expected %h got %h", $time, want.pc_now, rsp.pc_now);
          errors++;
        end
        if (rsp.halted !== want.halted) begin
          $display("%0t: halted expected %b got %b", $time, want.halted, rsp.halted);
          errors++;
        end
        if (rsp.executed_count !== want.executed_count) begin
          $display("%0t: executed_count expected %h got %h", $time,
                   want.executed_count, rsp.executed_count);
          errors++;
        end
        if (rsp.read_data !== want.read_data) begin
          $display("%0t: read_data expected %h got %h", $time, want.read_data,
                   rsp.read_data);
          errors++;
        end
      end
    end
  end

  // Stop a hung run
  initial begin : run_limit
    #4_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/eors_pkg.sv
hw/rtl/eors_req_if.sv
hw/rtl/eors_rsp_if.sv
hw/rtl/eors_regfile.sv
hw/rtl/eors_addr_wrap.sv
hw/rtl/eight_opcode_risc_step_core.sv
hw/rtl/eors_checker.sv
tb/eight_opcode_risc_step_core_test.sv
